>>> rtl/lip_pkg.sv
// lip_pkg: widths, payload structs and division pipeline types for the
// line intersection point block. No dependencies.
`default_nettype none
package lip_pkg;

   // coordinate and intermediate widths
   localparam int CW = 16;                   // input coordinate width
   localparam int DFW = CW + 1;              // point difference
   localparam int PW = 2 * CW;               // coordinate product
   localparam int CRW = 2 * CW + 1;          // line cross term c1/c2
   localparam int DPW = 2 * DFW;             // difference product
   localparam int DENW = 2 * DFW + 1;        // shared denominator
   localparam int NPW = CRW + DFW;           // numerator product
   localparam int NUMW = NPW + 1;            // numerator
   localparam int OW = 32;                   // result coordinate width
   localparam int QB = OW + 1;               // quotient bits developed
   localparam int WW = DENW + QB + 1;        // compare width in the divider

   localparam logic [QB-1:0] Q_POS_MAX = QB'(33'h0_7FFF_FFFF);
   localparam logic [QB-1:0] Q_NEG_MAX = QB'(33'h0_8000_0000);
   localparam logic signed [OW-1:0] SAT_POS = 32'sh7FFF_FFFF;
   localparam logic signed [OW-1:0] SAT_NEG = 32'sh8000_0000;

   typedef struct packed {
      logic signed [CW-1:0] line_a_x0;
      logic signed [CW-1:0] line_a_y0;
      logic signed [CW-1:0] line_a_x1;
      logic signed [CW-1:0] line_a_y1;
      logic signed [CW-1:0] line_b_x0;
      logic signed [CW-1:0] line_b_y0;
      logic signed [CW-1:0] line_b_x1;
      logic signed [CW-1:0] line_b_y1;
   } req_type;

   typedef struct packed {
      logic signed [OW-1:0] cross_x;
      logic signed [OW-1:0] cross_y;
      logic                 is_parallel;
      logic                 did_saturate;
   } rsp_type;

   // state carried through the restoring divider
   typedef struct packed {
      logic [DENW-1:0] den;
      logic [NUMW-1:0] rem_x;
      logic [NUMW-1:0] rem_y;
      logic [QB-1:0]   q_x;
      logic [QB-1:0]   q_y;
      logic            neg_x;
      logic            neg_y;
      logic            ovf_x;
      logic            ovf_y;
      logic            par;
   } div_type;

endpackage
`default_nettype wire

>>> rtl/lip_front.sv
// lip_front: five pipeline stages forming cross products, denominator and
// numerators, then magnitudes and signs for the divider. Uses lip_pkg.
`default_nettype none
module lip_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire logic            in_valid,
   input  lip_pkg::req_type     in_data,
   output logic                 out_valid,
   output lip_pkg::div_type     out_data
);
   import lip_pkg::*;

   logic [4:0] v_ff;

   // stage 1: point products and differences
   logic signed [PW-1:0]  pa1_ff, pa2_ff, pb1_ff, pb2_ff;
   logic signed [DFW-1:0] dxa_ff, dya_ff, dxb_ff, dyb_ff;
   logic signed [PW-1:0]  pa1_in, pa2_in, pb1_in, pb2_in;
   logic signed [DFW-1:0] dxa_in, dya_in, dxb_in, dyb_in;

   assign pa1_in = in_data.line_a_x0 * in_data.line_a_y1;
   assign pa2_in = in_data.line_a_x1 * in_data.line_a_y0;
   assign pb1_in = in_data.line_b_x0 * in_data.line_b_y1;
   assign pb2_in = in_data.line_b_x1 * in_data.line_b_y0;
   assign dxa_in = DFW'(in_data.line_a_x0) - DFW'(in_data.line_a_x1);
   assign dya_in = DFW'(in_data.line_a_y0) - DFW'(in_data.line_a_y1);
   assign dxb_in = DFW'(in_data.line_b_x0) - DFW'(in_data.line_b_x1);
   assign dyb_in = DFW'(in_data.line_b_y0) - DFW'(in_data.line_b_y1);

   // stage 2: line cross terms and denominator products
   logic signed [CRW-1:0] c1_ff, c2_ff;
   logic signed [DPW-1:0] dd1_ff, dd2_ff;
   logic signed [DFW-1:0] dxa2_ff, dya2_ff, dxb2_ff, dyb2_ff;
   logic signed [CRW-1:0] c1_in, c2_in;
   logic signed [DPW-1:0] dd1_in, dd2_in;

   assign c1_in  = CRW'(pa1_ff) - CRW'(pa2_ff);
   assign c2_in  = CRW'(pb1_ff) - CRW'(pb2_ff);
   assign dd1_in = dxa_ff * dyb_ff;
   assign dd2_in = dxb_ff * dya_ff;

   // stage 3: denominator and numerator products
   logic signed [DENW-1:0] den3_ff;
   logic signed [NPW-1:0]  npx1_ff, npx2_ff, npy1_ff, npy2_ff;
   logic signed [DENW-1:0] den3_in;
   logic signed [NPW-1:0]  npx1_in, npx2_in, npy1_in, npy2_in;

   // x numerator c1*dxb - c2*dxa, y numerator c1*dyb - c2*dya
   assign den3_in = DENW'(dd1_ff) - DENW'(dd2_ff);
   assign npx1_in = c1_ff * dxb2_ff;
   assign npx2_in = c2_ff * dxa2_ff;
   assign npy1_in = c1_ff * dyb2_ff;
   assign npy2_in = c2_ff * dya2_ff;

   // stage 4: numerators
   logic signed [NUMW-1:0] nx_ff, ny_ff, nx_in, ny_in;
   logic signed [DENW-1:0] den4_ff;

   assign nx_in = NUMW'(npx1_ff) - NUMW'(npx2_ff);
   assign ny_in = NUMW'(npy1_ff) - NUMW'(npy2_ff);

   // stage 5: magnitudes, quotient signs, range check before division
   div_type         div_ff, div_in;
   logic [DENW-1:0] den_mag;
   logic [NUMW-1:0] nx_mag, ny_mag;
   logic [WW-1:0]   den_top;

   assign den_mag = den4_ff[DENW-1] ? DENW'(-den4_ff) : DENW'(den4_ff);
   assign nx_mag  = nx_ff[NUMW-1] ? NUMW'(-nx_ff) : NUMW'(nx_ff);
   assign ny_mag  = ny_ff[NUMW-1] ? NUMW'(-ny_ff) : NUMW'(ny_ff);
   assign den_top = WW'(den_mag) << QB;

   always_comb begin
      div_in       = '0;
      div_in.den   = den_mag;
      div_in.rem_x = nx_mag;
      div_in.rem_y = ny_mag;
      div_in.neg_x = nx_ff[NUMW-1] ^ den4_ff[DENW-1];
      div_in.neg_y = ny_ff[NUMW-1] ^ den4_ff[DENW-1];
      div_in.ovf_x = WW'(nx_mag) >= den_top;
      div_in.ovf_y = WW'(ny_mag) >= den_top;
      div_in.par   = (den4_ff == '0);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[3:0], in_valid};
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (en) begin
         pa1_ff  <= pa1_in;
         pa2_ff  <= pa2_in;
         pb1_ff  <= pb1_in;
         pb2_ff  <= pb2_in;
         dxa_ff  <= dxa_in;
         dya_ff  <= dya_in;
         dxb_ff  <= dxb_in;
         dyb_ff  <= dyb_in;
         c1_ff   <= c1_in;
         c2_ff   <= c2_in;
         dd1_ff  <= dd1_in;
         dd2_ff  <= dd2_in;
         dxa2_ff <= dxa_ff;
         dya2_ff <= dya_ff;
         dxb2_ff <= dxb_ff;
         dyb2_ff <= dyb_ff;
         den3_ff <= den3_in;
         npx1_ff <= npx1_in;
         npx2_ff <= npx2_in;
         npy1_ff <= npy1_in;
         npy2_ff <= npy2_in;
         nx_ff   <= nx_in;
         ny_ff   <= ny_in;
         den4_ff <= den3_ff;
         div_ff  <= div_in;
      end
   end

   assign out_valid = v_ff[4];
   assign out_data  = div_ff;

endmodule
`default_nettype wire

>>> rtl/lip_div_stage.sv
// lip_div_stage: one registered restoring division step for both
// numerators against the shared denominator. Uses lip_pkg.
`default_nettype none
module lip_div_stage #(
   parameter int BIT = 0
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire logic            in_valid,
   input  lip_pkg::div_type     in_data,
   output logic                 out_valid,
   output lip_pkg::div_type     out_data
);
   import lip_pkg::*;

   logic          v_ff;
   div_type       d_ff, d_in;
   logic [WW-1:0] dsh;
   logic          ge_x, ge_y;

   // shifted divisor against each partial remainder
   assign dsh  = WW'(in_data.den) << BIT;
   assign ge_x = WW'(in_data.rem_x) >= dsh;
   assign ge_y = WW'(in_data.rem_y) >= dsh;

   always_comb begin
      d_in = in_data;
      if (ge_x) begin
         d_in.rem_x    = in_data.rem_x - dsh[NUMW-1:0];
         d_in.q_x[BIT] = 1'b1;
      end
      if (ge_y) begin
         d_in.rem_y    = in_data.rem_y - dsh[NUMW-1:0];
         d_in.q_y[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in;
      end
   end

   assign out_valid = v_ff;
   assign out_data  = d_ff;

endmodule
`default_nettype wire

>>> rtl/line_intersection_point.sv
// line_intersection_point: each accepted transaction passes 5 arithmetic
// stages, 33 division stages and 1 output register; the one-bit-per-stage
// divider chain sets the depth. Throughput one transaction per cycle, but
// the whole pipeline halts while a result waits on rsp_ready. Synchronous
// reset clears all valid bits; no state survives between items.
`default_nettype none
module line_intersection_point (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  lip_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output lip_pkg::rsp_type rsp_data
);
   import lip_pkg::*;

   logic    en;
   logic    fv;
   div_type fd;
   logic    cv [QB+1];
   div_type cd [QB+1];

   // pipeline advances unless the output holds an untaken result
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   lip_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (fv),
      .out_data  (fd)
   );

   assign cv[0] = fv;
   assign cd[0] = fd;

   // quotient bits, most significant first
   for (genvar k = 0; k < QB; k++) begin : g_div
      lip_div_stage #(.BIT(QB - 1 - k)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (cv[k]),
         .in_data   (cd[k]),
         .out_valid (cv[k+1]),
         .out_data  (cd[k+1])
      );
   end

   // sign, saturation and parallel handling
   div_type q;
   logic    sat_x, sat_y;
   rsp_type rsp_in, rsp_ff;
   logic    rv_ff;

   assign q     = cd[QB];
   assign sat_x = q.ovf_x || (q.neg_x ? (q.q_x > Q_NEG_MAX) : (q.q_x > Q_POS_MAX));
   assign sat_y = q.ovf_y || (q.neg_y ? (q.q_y > Q_NEG_MAX) : (q.q_y > Q_POS_MAX));

   always_comb begin
      rsp_in = '0;
      if (q.par) begin
         rsp_in.is_parallel = 1'b1;
      end else begin
         if (sat_x) begin
            rsp_in.cross_x = q.neg_x ? SAT_NEG : SAT_POS;
         end else begin
            rsp_in.cross_x = q.neg_x ? -$signed(q.q_x[OW-1:0]) : $signed(q.q_x[OW-1:0]);
         end
         if (sat_y) begin
            rsp_in.cross_y = q.neg_y ? SAT_NEG : SAT_POS;
         end else begin
            rsp_in.cross_y = q.neg_y ? -$signed(q.q_y[OW-1:0]) : $signed(q.q_y[OW-1:0]);
         end
         rsp_in.did_saturate = sat_x || sat_y;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (en) begin
         rv_ff <= cv[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_par_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_parallel |->
         rsp_data.cross_x == '0 && rsp_data.cross_y == '0 && !rsp_data.did_saturate)
      else $error("parallel result with nonzero coordinates");

   a_sat_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.did_saturate |->
         rsp_data.cross_x == SAT_POS || rsp_data.cross_x == SAT_NEG ||
         rsp_data.cross_y == SAT_POS || rsp_data.cross_y == SAT_NEG)
      else $error("saturation flag without clamped coordinate");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(cv[QB]) && $stable(cv[0]))
      else $error("pipeline moved during stall");

endmodule
`default_nettype wire

>>> verif/line_intersection_point_tb.sv
// line_intersection_point_tb: self-checking bench for the line crossing block.
// Depends on lip_pkg and line_intersection_point; predicts results with wide integer math.
`timescale 1ns / 100ps
`default_nettype none
module line_intersection_point_tb;
   import lip_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   req_type pending_lines[$];
   rsp_type expected_points[$];
   int      error_count;
   int      points_checked;
   int      parallel_seen;
   int      saturate_seen;
   bit      stimulus_done;
   bit      hold_rsp;
   int      send_gap;
   int      recv_gap;

   line_intersection_point dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // idle draw: often zero so there are stretches with no gaps
   function automatic int draw_gap();
      if ($urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 18);
   endfunction

   // truncating divide with 32-bit clamp
   function automatic logic signed [31:0] clamp_quotient(logic signed [127:0] num,
         logic signed [127:0] den, ref bit sat);
      logic signed [127:0] quot;
      quot = num / den;
      if (quot > 128'sd2147483647) begin
         sat = 1'b1;
         return 32'sh7FFF_FFFF;
      end
      if (quot < -128'sd2147483648) begin
         sat = 1'b1;
         return 32'sh8000_0000;
      end
      return quot[31:0];
   endfunction

   // crossing point of the two lines in determinant form
   function automatic rsp_type predict_crossing(req_type lines);
      logic signed [127:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
      logic signed [127:0] cross_a, cross_b, dxa, dya, dxb, dyb, den;
      rsp_type r;
      bit sat;
      ax0 = lines.line_a_x0; ay0 = lines.line_a_y0;
      ax1 = lines.line_a_x1; ay1 = lines.line_a_y1;
      bx0 = lines.line_b_x0; by0 = lines.line_b_y0;
      bx1 = lines.line_b_x1; by1 = lines.line_b_y1;
      cross_a = ax0 * ay1 - ax1 * ay0;
      cross_b = bx0 * by1 - bx1 * by0;
      dxa = ax0 - ax1; dya = ay0 - ay1;
      dxb = bx0 - bx1; dyb = by0 - by1;
      den = dxa * dyb - dxb * dya;
      r = '0;
      sat = 1'b0;
      if (den == 0) begin
         r.is_parallel = 1'b1;
         return r;
      end
      r.cross_x = clamp_quotient(cross_a * dxb - cross_b * dxa, den, sat);
      r.cross_y = clamp_quotient(cross_a * dyb - cross_b * dya, den, sat);
      r.did_saturate = sat;
      return r;
   endfunction

   function automatic req_type random_lines();
      req_type l;
      int mode;
      mode = $urandom_range(0, 9);
      l = req_type'({$urandom, $urandom, $urandom, $urandom});
      if (mode < 3) begin
         // small coordinates
         l.line_a_x0 = 16'($signed($urandom_range(0, 63)) - 32);
         l.line_a_y0 = 16'($signed($urandom_range(0, 63)) - 32);
         l.line_a_x1 = 16'($signed($urandom_range(0, 63)) - 32);
         l.line_a_y1 = 16'($signed($urandom_range(0, 63)) - 32);
         l.line_b_x0 = 16'($signed($urandom_range(0, 63)) - 32);
         l.line_b_y0 = 16'($signed($urandom_range(0, 63)) - 32);
         l.line_b_x1 = 16'($signed($urandom_range(0, 63)) - 32);
         l.line_b_y1 = 16'($signed($urandom_range(0, 63)) - 32);
      end else if (mode == 3) begin
         // parallel: line b is line a shifted
         l.line_b_x0 = l.line_a_x0 + 16'($urandom_range(0, 255));
         l.line_b_y0 = l.line_a_y0 + 16'($urandom_range(0, 255));
         l.line_b_x1 = l.line_b_x0 + (l.line_a_x1 - l.line_a_x0);
         l.line_b_y1 = l.line_b_y0 + (l.line_a_y1 - l.line_a_y0);
      end else if (mode == 4) begin
         // nearly parallel, tends to saturate
         l.line_b_x0 = l.line_a_x0 + 16'($urandom_range(0, 3));
         l.line_b_y0 = l.line_a_y0 + 16'($urandom_range(0, 3));
         l.line_b_x1 = l.line_a_x1 + 16'($urandom_range(0, 3));
         l.line_b_y1 = l.line_a_y1 + 16'($urandom_range(0, 3));
      end else if (mode == 5) begin
         // degenerate line a
         l.line_a_x1 = l.line_a_x0;
         l.line_a_y1 = l.line_a_y0;
      end
      return l;
   endfunction

   // stimulus: directed cases then random
   initial begin
      req_type l;
      logic signed [15:0] ext[4];
      ext = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};
      stimulus_done = 1'b0;
      // axis lines crossing at origin, and shifted
      pending_lines.push_back('{-16'sd16, 0, 16'sd16, 0, 0, -16'sd16, 0, 16'sd16});
      pending_lines.push_back('{0, 16'sd32, 16'sd160, 16'sd32, 16'sd48, 0, 16'sd48, 16'sd80});
      // identical lines, parallel lines, all points equal
      pending_lines.push_back('{0, 0, 16'sd16, 16'sd16, 0, 0, 16'sd16, 16'sd16});
      pending_lines.push_back('{0, 0, 16'sd16, 16'sd16, 0, 16'sd8, 16'sd16, 16'sd24});
      pending_lines.push_back('0);
      // fraction truncation toward zero, both signs
      pending_lines.push_back('{0, 0, 16'sd3, 16'sd1, 0, 16'sd1, 16'sd1, 0});
      pending_lines.push_back('{0, 0, -16'sd3, 16'sd1, 0, 16'sd1, -16'sd1, 0});
      // nearly parallel long lines that meet at a shared extreme endpoint
      pending_lines.push_back('{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF,
                                16'sh8000, 16'sh8001, 16'sh7FFF, 16'sh7FFF});
      pending_lines.push_back('{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF,
                                16'sh7FFF, 16'sh8001, 16'sh8000, 16'sh7FFF});
      // extreme corners
      for (int i = 0; i < 14; i++) begin
         l.line_a_x0 = ext[i % 4];        l.line_a_y0 = ext[(i / 4) % 4];
         l.line_a_x1 = ext[(i + 1) % 4];  l.line_a_y1 = ext[(i + 2) % 4];
         l.line_b_x0 = ext[(i + 3) % 4];  l.line_b_y0 = ext[(i / 2) % 4];
         l.line_b_x1 = ext[(i + 2) % 4];  l.line_b_y1 = ext[(i / 3) % 4];
         pending_lines.push_back(l);
      end
      for (int i = 0; i < 1430; i++) pending_lines.push_back(random_lines());
      stimulus_done = 1'b1;
   end

   // driver; sender pauses once until the pipeline drains
   int sent_count;
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         req_data   <= '0;
         send_gap   <= 0;
         sent_count <= 0;
      end else if (req_valid && !req_ready) begin
         // hold the transaction
      end else if (send_gap > 0) begin
         req_valid <= 1'b0;
         send_gap  <= send_gap - 1;
      end else if (sent_count == 700 && expected_points.size() != 0) begin
         req_valid <= 1'b0;
      end else if (pending_lines.size() != 0) begin
         req_valid  <= 1'b1;
         req_data   <= pending_lines.pop_front();
         sent_count <= sent_count + 1;
         send_gap   <= (sent_count > 300 && sent_count < 500) ? 0 : draw_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // capture expectations for accepted transactions
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         expected_points.push_back(predict_crossing(req_data));
   end

   // long receiver hold-off so the pipeline fills and stalls input
   initial begin
      hold_rsp = 1'b0;
      wait (sent_count == 350);
      hold_rsp = 1'b1;
      repeat (150) @(posedge clock);
      hold_rsp = 1'b0;
   end

   // monitor and checker
   always @(posedge clock) begin
      rsp_type exp_r;
      int      gap_draw;
      if (reset) begin
         rsp_ready      <= 1'b0;
         recv_gap       <= 0;
         error_count    <= 0;
         points_checked <= 0;
         parallel_seen  <= 0;
         saturate_seen  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               $display("%0t: unexpected transaction expected none actual %h", $time,
                        rsp_data);
               error_count <= error_count + 1;
            end else begin
               exp_r = expected_points.pop_front();
               if (exp_r !== rsp_data) begin
                  $display("%0t: mismatch exp x=%0d y=%0d p=%b s=%b act x=%0d y=%0d p=%b s=%b",
                           $time, exp_r.cross_x, exp_r.cross_y, exp_r.is_parallel,
                           exp_r.did_saturate, rsp_data.cross_x, rsp_data.cross_y,
                           rsp_data.is_parallel, rsp_data.did_saturate);
                  error_count <= error_count + 1;
               end
               points_checked <= points_checked + 1;
               parallel_seen  <= parallel_seen + exp_r.is_parallel;
               saturate_seen  <= saturate_seen + exp_r.did_saturate;
            end
         end
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            rsp_ready <= 1'b0;
            recv_gap  <= recv_gap - 1;
         end else if (rsp_valid && rsp_ready) begin
            // a zero draw keeps ready high for back to back results
            gap_draw  = (points_checked > 900 && points_checked < 1100) ? 0 : draw_gap();
            recv_gap  <= gap_draw;
            rsp_ready <= (gap_draw == 0);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // end of run
   initial begin
      wait (stimulus_done && pending_lines.size() == 0 && !reset);
      @(posedge clock);
      wait (!req_valid && expected_points.size() == 0);
      repeat (100) @(posedge clock);
      $display("checked %0d crossing points, %0d parallel, %0d saturated", points_checked,
               parallel_seen, saturate_seen);
      if (error_count == 0 && expected_points.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #4000000;
      $display("TB_ERROR");
      $finish;
   end
endmodule
`default_nettype wire
